FILE: hw/rtl/rcfl_pkg.sv
// ----------------------------------------------------------------------------
// rcfl_pkg
// Types and constants shared by the reference-counted block free list.
// ----------------------------------------------------------------------------
package rcfl_pkg;

  localparam int BLOCKS = 64;
  localparam int ID_W   = 6;
  localparam int CNT_W  = 7;
  localparam int REF_W  = 8;
  localparam int STAT_W = 3;
  localparam int FUNC_W = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_COMMIT  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_ID    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_FREE  = 3'd4;

  // Configuration register indexes.
  localparam logic REG_BLOCKS_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    BS_FREE    = 2'd0,
    BS_WRITING = 2'd1,
    BS_READY   = 2'd2
  } blk_state_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // One block's entry in the block table.
  typedef struct packed {
    logic [CNT_W-1:0] link;
    blk_state_t       st;
    logic [REF_W-1:0] refs;
  } ent_t;

endpackage

FILE: hw/rtl/rcfl_if.sv
// ----------------------------------------------------------------------------
// rcfl_in_if / rcfl_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface rcfl_in_if;
  import rcfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   target_block;
  logic [REF_W-1:0]  ref_total;

  modport source (output valid, func, target_block, ref_total, input ready);
  modport sink   (input valid, func, target_block, ref_total, output ready);
endinterface

interface rcfl_out_if;
  import rcfl_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   granted_block;
  logic [CNT_W-1:0]  free_blocks;
  logic              was_freed;

  modport source (output valid, status, granted_block, free_blocks, was_freed, input ready);
  modport sink   (input valid, status, granted_block, free_blocks, was_freed, output ready);
endinterface

FILE: hw/rtl/refcounted_block_free_list_top.sv
// ----------------------------------------------------------------------------
// refcounted_block_free_list_top
// Buffer block manager with a LIFO free stack and per-block reference counts.
// ----------------------------------------------------------------------------
// Each operation beat passes through two states: in the cycle it is accepted
// the block table is read at the addressed entry (the stack top for an
// allocate, target_block otherwise), and in the update state the entry is
// updated, written back and the result is loaded into the output register.
// That split is set by the registered read of the single block table, which
// holds the next link, the state and the reference count of each block. A
// new beat is taken as soon as the previous one has been written back, even
// while its result still waits in the output register; only a full output
// register holds an operation in its update state. Writing blocks_in_use
// rebuilds the free list by clearing a row of per-block valid bits; an entry
// that is not valid reads as its rebuilt value (free, count zero, linked to
// the next block), so no clearing pass over the table is needed after reset
// or after a write.
module refcounted_block_free_list_top (
  input  logic                  clk,
  input  logic                  rst_n,
  rcfl_in_if.sink               in_ch,
  rcfl_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import rcfl_pkg::*;

  // Block table and its valid bits.
  ent_t              mem [BLOCKS];
  ent_t              rd_data_r;
  logic [BLOCKS-1:0] valid_r;

  fsm_t              fsm_r, fsm_nxt;
  logic [CNT_W-1:0]  blocks_r;
  logic [CNT_W-1:0]  free_top_r, free_top_nxt;
  logic [CNT_W-1:0]  free_total_r, free_total_nxt;

  // Operation held for its update state.
  logic [FUNC_W-1:0] func_r;
  logic [ID_W-1:0]   addr_r;
  logic [REF_W-1:0]  refs_in_r;

  // Output register.
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]   granted_r, granted_nxt;
  logic              freed_r, freed_nxt;

  logic              in_acc;
  logic              exec_done;
  logic              cfg_wr;
  logic [CNT_W-1:0]  cfg_count;
  logic              mem_we;
  ent_t              wr_data;
  ent_t              cur;
  logic [CNT_W-1:0]  addr_ext;
  logic [CNT_W-1:0]  addr_inc;
  logic              id_bad;

  // ---------------------------------------------------------------------------
  // Configuration port. The count is clamped to 1..BLOCKS on the way in.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == REG_BLOCKS_IN_USE);

  always_comb begin
    cfg_count = cfg_pwdata[CNT_W-1:0];
    if (cfg_count == '0) begin
      cfg_count = CNT_W'(1);
    end else if (cfg_count > CNT_W'(BLOCKS)) begin
      cfg_count = CNT_W'(BLOCKS);
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_BLOCKS_IN_USE) ?
                      {{(32-CNT_W){1'b0}}, blocks_r} : 32'd0;

  // ---------------------------------------------------------------------------
  // Handshakes. A beat enters only in the idle state, so the read of one beat
  // never meets the write-back of the previous one at the table.
  // ---------------------------------------------------------------------------
  assign in_ch.ready = (fsm_r == FSM_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign exec_done   = (fsm_r == FSM_EXEC) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.granted_block = granted_r;
  assign out_ch.free_blocks   = free_total_r;
  assign out_ch.was_freed     = freed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= FSM_IDLE;
    end else begin
      fsm_r <= fsm_nxt;
    end
  end

  always_comb begin
    fsm_nxt = fsm_r;
    case (fsm_r)
      FSM_IDLE: if (in_acc) fsm_nxt = FSM_EXEC;
      FSM_EXEC: if (exec_done) fsm_nxt = FSM_IDLE;
      default:  fsm_nxt = FSM_IDLE;
    endcase
  end

  // Capture the beat and read its entry. An allocate reads the stack top; when
  // the stack is empty the top is out of range and the read is unused.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r    <= in_ch.func;
      refs_in_r <= in_ch.ref_total;
      if (in_ch.func == FN_ALLOC) begin
        addr_r    <= free_top_r[ID_W-1:0];
        rd_data_r <= mem[free_top_r[ID_W-1:0]];
      end else begin
        addr_r    <= in_ch.target_block;
        rd_data_r <= mem[in_ch.target_block];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Update state: modify the entry and decide the result.
  // ---------------------------------------------------------------------------
  assign addr_ext = {1'b0, addr_r};
  assign addr_inc = addr_ext + CNT_W'(1);
  assign id_bad   = (addr_ext >= blocks_r);

  always_comb begin
    // An entry not written since the last rebuild reads as its rebuilt value.
    if (valid_r[addr_r]) begin
      cur = rd_data_r;
    end else begin
      cur.link = (addr_inc < blocks_r) ? addr_inc : CNT_W'(BLOCKS);
      cur.st   = BS_FREE;
      cur.refs = '0;
    end

    wr_data        = cur;
    mem_we         = 1'b0;
    status_nxt     = STAT_OK;
    granted_nxt    = '0;
    freed_nxt      = 1'b0;
    free_top_nxt   = free_top_r;
    free_total_nxt = free_total_r;

    case (func_r)
      FN_ALLOC: begin
        if (free_total_r == '0 || free_top_r >= blocks_r) begin
          status_nxt = STAT_EMPTY;
        end else if (cur.st != BS_FREE) begin
          status_nxt = STAT_NOT_FREE;
        end else begin
          wr_data.st     = BS_WRITING;
          mem_we         = 1'b1;
          free_top_nxt   = cur.link;
          free_total_nxt = free_total_r - CNT_W'(1);
          granted_nxt    = addr_r;
        end
      end
      FN_COMMIT: begin
        if (id_bad) begin
          status_nxt = STAT_BAD_ID;
        end else begin
          wr_data.st   = BS_READY;
          wr_data.refs = refs_in_r;
          mem_we       = 1'b1;
        end
      end
      FN_RELEASE: begin
        if (id_bad) begin
          status_nxt = STAT_BAD_ID;
        end else if (cur.refs == '0) begin
          status_nxt = STAT_UNDERFLOW;
        end else begin
          wr_data.refs = cur.refs - REF_W'(1);
          mem_we       = 1'b1;
          // The last reference of a ready block pushes it back on the stack.
          if (cur.refs == REF_W'(1) && cur.st == BS_READY) begin
            wr_data.st   = BS_FREE;
            wr_data.link = free_top_r;
            free_top_nxt = addr_ext;
            if (free_total_r < blocks_r) begin
              free_total_nxt = free_total_r + CNT_W'(1);
            end
            freed_nxt = 1'b1;
          end
        end
      end
      default: begin
        // The unused operation code changes nothing and reports success.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (exec_done && mem_we) begin
      mem[addr_r] <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Control state: list head, free count, valid bits, output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocks_r     <= CNT_W'(BLOCKS);
      free_top_r   <= '0;
      free_total_r <= CNT_W'(BLOCKS);
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else if (cfg_wr) begin
      blocks_r     <= cfg_count;
      free_top_r   <= '0;
      free_total_r <= cfg_count;
      valid_r      <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (exec_done) begin
        free_top_r   <= free_top_nxt;
        free_total_r <= free_total_nxt;
        out_valid_r  <= 1'b1;
        if (mem_we) begin
          valid_r[addr_r] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
      freed_r   <= freed_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_free_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= blocks_r)
    else $error("free count exceeds the managed block count");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && exec_done) |-> (fsm_r == FSM_EXEC))
    else $error("block table written outside the update cycle");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !cfg_wr |=> (fsm_r == FSM_EXEC))
    else $error("accepted beat did not reach the update cycle");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fsm_r == FSM_EXEC))
    else $error("result appeared without an update cycle");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != STAT_OK) |-> (granted_r == '0 && !freed_r))
    else $error("failed operation reports a grant or a freed block");

endmodule
